@@ hw/rtl/slpg_pkg.sv @@
// ----------------------------------------------------------------------------
// slpg_pkg
// Types, codes and timing constants shared by the status LED pattern
// generator and its level decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slpg_pkg;

	typedef enum logic [1:0] {
		OP_TICK        = 2'd0,
		OP_FLASH       = 2'd1,
		OP_QUIET_SET   = 2'd2,
		OP_QUIET_CLEAR = 2'd3
	} op_t;

	localparam logic [3:0] ST_BOOT     = 4'd0;
	localparam logic [3:0] ST_NORMAL   = 4'd1;
	localparam logic [3:0] ST_PROV_AP  = 4'd2;
	localparam logic [3:0] ST_PROV_BLE = 4'd3;
	localparam logic [3:0] ST_WIFI     = 4'd4;
	localparam logic [3:0] ST_CLOUD    = 4'd5;
	localparam logic [3:0] ST_RF_LEARN = 4'd6;
	localparam logic [3:0] ST_OTA      = 4'd7;
	localparam logic [3:0] ST_ERROR    = 4'd8;

	localparam int TIME_W  = 32;
	localparam int RECIP_W = 25;
	localparam int MOD_W   = 13;
	localparam int PHASE_W = 13;
	localparam int RAW_W   = 14;
	localparam int PROD_W  = TIME_W + RECIP_W;

	localparam logic [TIME_W-1:0] QUIET_MS       = 32'd10000;
	localparam logic [TIME_W-1:0] FLASH_LEAD_MS  = 32'd50;
	localparam logic [TIME_W-1:0] FLASH_ON_MS    = 32'd80;
	localparam logic [TIME_W-1:0] FLASH_GAP_MS   = 32'd80;
	localparam logic [TIME_W-1:0] FLASH_TAIL_MS  = 32'd50;
	localparam logic [TIME_W-1:0] FLASH_ON1_END  = FLASH_LEAD_MS + FLASH_ON_MS;
	localparam logic [TIME_W-1:0] FLASH_ON2_BEG  = FLASH_ON1_END + FLASH_GAP_MS;
	localparam logic [TIME_W-1:0] FLASH_ON2_END  = FLASH_ON2_BEG + FLASH_ON_MS;
	localparam logic [TIME_W-1:0] FLASH_TOTAL_MS = FLASH_ON2_END + FLASH_TAIL_MS;

	localparam logic [2:0] REG_ACTIVE_HIGH = 3'd0;

	typedef struct packed {
		op_t         operation;
		logic [31:0] now_ms;
		logic [3:0]  app_state;
	} item_t;

	typedef struct packed {
		logic pin_level;
		logic led_on;
		logic flash_busy;
		logic quiet_hold_set;
	} result_t;

	typedef struct packed {
		logic [RECIP_W-1:0] recip;
		logic [MOD_W-1:0]   modulus;
	} phase_div_t;

	// floor(2^32 / modulus): quotient estimate is exact or one short
	function automatic phase_div_t phase_div(input logic [3:0] st);
		phase_div_t d;
		unique case (st)
			ST_ERROR:    d = '{recip: 25'd3579139,  modulus: 13'd1200};
			ST_OTA:      d = '{recip: 25'd7158278,  modulus: 13'd600};
			ST_RF_LEARN: d = '{recip: 25'd14316557, modulus: 13'd300};
			ST_NORMAL:   d = '{recip: 25'd1073741,  modulus: 13'd4000};
			ST_PROV_AP:  d = '{recip: 25'd2147483,  modulus: 13'd2000};
			ST_PROV_BLE: d = '{recip: 25'd17895697, modulus: 13'd240};
			ST_WIFI:     d = '{recip: 25'd858993,   modulus: 13'd5000};
			default:     d = '{recip: 25'd4294967,  modulus: 13'd1000};
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/slpg_level.sv @@
// ----------------------------------------------------------------------------
// slpg_level
// Picks the logical LED level for a tick from flash timing, quiet hold and
// the per-state pattern phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slpg_level (
	input  logic [3:0]                 app_state,
	input  logic [slpg_pkg::PHASE_W-1:0] phase,
	input  logic                       flash_live,
	input  logic [31:0]                flash_elapsed,
	input  logic                       quiet_hold,
	output logic                       level
);
	import slpg_pkg::*;

	logic flash_level;
	logic state_level;

	assign flash_level =
		(flash_elapsed >= FLASH_LEAD_MS && flash_elapsed < FLASH_ON1_END) ||
		(flash_elapsed >= FLASH_ON2_BEG && flash_elapsed < FLASH_ON2_END);

	always_comb begin
		unique case (app_state)
			ST_ERROR:    state_level = phase < 13'd80 ||
					(phase >= 13'd160 && phase < 13'd240) ||
					(phase >= 13'd320 && phase < 13'd400);
			ST_OTA:      state_level = phase < 13'd100 ||
					(phase >= 13'd200 && phase < 13'd300);
			ST_RF_LEARN: state_level = phase < 13'd150;
			ST_BOOT:     state_level = !quiet_hold && (phase < 13'd120 ||
					(phase >= 13'd240 && phase < 13'd360));
			ST_NORMAL:   state_level = !quiet_hold && phase < 13'd50;
			ST_PROV_AP:  state_level = !quiet_hold && phase < 13'd250;
			ST_PROV_BLE: state_level = !quiet_hold && phase < 13'd120;
			ST_WIFI:     state_level = !quiet_hold && phase < 13'd3000;
			ST_CLOUD:    state_level = !quiet_hold;
			default:     state_level = 1'b0;
		endcase
	end

	assign level = flash_live ? flash_level : state_level;

endmodule

`default_nettype wire

@@ hw/rtl/status_led_pattern_generator.sv @@
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Status LED blink pattern generator. Each item is a tick, a relay
// double-flash start, or a quiet-hold set or clear, stamped with a
// millisecond time; every item returns one result with the pin level, the
// logical LED state, and the flash and quiet-hold flags. One item is taken
// per cycle unless result_stall holds the pipeline back; the pattern phase
// (time modulo the state's period) is computed by a reciprocal multiply, a
// back-multiply and a one-step correction, each in its own stage. Overlay
// state updates in the last stage only, so items stay in order back to back.
// Register active_high (byte address 0, reset 1) sets the pin polarity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module status_led_pattern_generator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  slpg_pkg::item_t         item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output slpg_pkg::result_t       result,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import slpg_pkg::*;

	logic                 active_high_q;
	logic                 flash_active_q;
	logic [TIME_W-1:0]    flash_start_q;
	logic [TIME_W-1:0]    quiet_deadline_q;
	logic                 led_state_q;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	op_t                  op_s1, op_s2, op_s3, op_s4;
	logic [TIME_W-1:0]    now_s1, now_s2, now_s3, now_s4;
	logic [3:0]           st_s1, st_s2, st_s3, st_s4;
	phase_div_t           div_s1;
	logic [MOD_W-1:0]     mod_s2, mod_s3, mod_s4;
	logic [RECIP_W-1:0]   quot_s2;
	logic [TIME_W-1:0]    back_s3;
	logic [PHASE_W-1:0]   phase_s4;

	logic [PROD_W-1:0]    prod;
	logic [TIME_W-1:0]    diff;
	logic [RAW_W-1:0]     rem_raw;

	logic [TIME_W-1:0]    elapsed;
	logic                 expired;
	logic                 flash_live;
	logic                 quiet_hold;
	logic                 level;
	logic                 flash_nxt;
	logic [TIME_W-1:0]    start_nxt;
	logic [TIME_W-1:0]    deadline_nxt;
	logic                 led_nxt;
	logic                 cfg_write;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && paddr[2] == REG_ACTIVE_HIGH[2];
	assign prdata    = (paddr[2] == REG_ACTIVE_HIGH[2]) ? {31'd0, active_high_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg_write) begin
			active_high_q <= pwdata[0];
		end
	end

	// stage advance
	assign ready_s5   = !result_valid || !result_stall;
	assign ready_s4   = !v_s4 || ready_s5;
	assign ready_s3   = !v_s3 || ready_s4;
	assign ready_s2   = !v_s2 || ready_s3;
	assign ready_s1   = !v_s1 || ready_s2;
	assign item_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= item_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
			if (ready_s4) v_s4 <= v_s3;
			if (ready_s5) result_valid <= v_s4;
		end
	end

	// stage 1: capture item, pick the period
	always_ff @(posedge clk) begin
		if (ready_s1 && item_valid) begin
			op_s1  <= item.operation;
			now_s1 <= item.now_ms;
			st_s1  <= item.app_state;
			div_s1 <= phase_div(item.app_state);
		end
	end

	// stage 2: quotient estimate
	assign prod = PROD_W'(now_s1) * PROD_W'(div_s1.recip);

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			op_s2   <= op_s1;
			now_s2  <= now_s1;
			st_s2   <= st_s1;
			mod_s2  <= div_s1.modulus;
			quot_s2 <= prod[PROD_W-1:TIME_W];
		end
	end

	// stage 3: back-multiply
	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			op_s3   <= op_s2;
			now_s3  <= now_s2;
			st_s3   <= st_s2;
			mod_s3  <= mod_s2;
			back_s3 <= TIME_W'(quot_s2) * TIME_W'(mod_s2);
		end
	end

	// stage 4: remainder with one correction step
	assign diff    = now_s3 - back_s3;
	assign rem_raw = diff[RAW_W-1:0];

	always_ff @(posedge clk) begin
		if (ready_s4 && v_s3) begin
			op_s4    <= op_s3;
			now_s4   <= now_s3;
			st_s4    <= st_s3;
			mod_s4   <= mod_s3;
			phase_s4 <= (rem_raw >= RAW_W'(mod_s3)) ?
				PHASE_W'(rem_raw - RAW_W'(mod_s3)) : PHASE_W'(rem_raw);
		end
	end

	// stage 5: overlay state and level
	assign elapsed    = (now_s4 < flash_start_q) ? '0 : now_s4 - flash_start_q;
	assign expired    = elapsed >= FLASH_TOTAL_MS;
	assign flash_live = flash_active_q && !expired;
	assign quiet_hold = quiet_deadline_q != '0 && now_s4 < quiet_deadline_q;

	slpg_level u_level (
		.app_state     (st_s4),
		.phase         (phase_s4),
		.flash_live    (flash_live),
		.flash_elapsed (elapsed),
		.quiet_hold    (quiet_hold),
		.level         (level)
	);

	always_comb begin
		flash_nxt    = flash_active_q;
		start_nxt    = flash_start_q;
		deadline_nxt = quiet_deadline_q;
		led_nxt      = led_state_q;
		case (op_s4)
			OP_TICK: begin
				flash_nxt = flash_live;
				led_nxt   = level;
			end
			OP_FLASH: begin
				flash_nxt = 1'b1;
				start_nxt = now_s4;
			end
			OP_QUIET_SET: begin
				deadline_nxt = now_s4 + QUIET_MS;
			end
			default: begin
				deadline_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_active_q   <= 1'b0;
			flash_start_q    <= '0;
			quiet_deadline_q <= '0;
			led_state_q      <= 1'b0;
		end else if (ready_s5 && v_s4) begin
			flash_active_q   <= flash_nxt;
			flash_start_q    <= start_nxt;
			quiet_deadline_q <= deadline_nxt;
			led_state_q      <= led_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && v_s4) begin
			result.pin_level      <= active_high_q ? led_nxt : !led_nxt;
			result.led_on         <= led_nxt;
			result.flash_busy     <= flash_nxt;
			result.quiet_hold_set <= deadline_nxt != '0;
		end
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> RAW_W'(phase_s4) < RAW_W'(mod_s4))
		else $error("pattern phase not below its period");

	a_flash_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ready_s5 |=> result.flash_busy == flash_active_q)
		else $error("flash flag in result disagrees with state");

	a_quiet_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ready_s5 |=> result.quiet_hold_set == (quiet_deadline_q != '0))
		else $error("quiet hold flag in result disagrees with state");

	a_led_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ready_s5 |=> result.led_on == led_state_q)
		else $error("led level in result disagrees with state");
`endif

endmodule

`default_nettype wire
